// ===== design/int64_alu_with_division_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef INT64_ALU_WITH_DIVISION_CORE_MACROS_SVH
`define INT64_ALU_WITH_DIVISION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I64A_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked also during reset.
`define I64A_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/i64alu_pkg.sv =====
package i64alu_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned KindW  = 5;
  localparam int unsigned HalfW  = DataW / 2;
  localparam int unsigned ShiftW = 6;

  localparam logic [KindW-1:0] KIND_ADD  = 5'd0;
  localparam logic [KindW-1:0] KIND_SUB  = 5'd1;
  localparam logic [KindW-1:0] KIND_MUL  = 5'd2;
  localparam logic [KindW-1:0] KIND_DIV  = 5'd3;
  localparam logic [KindW-1:0] KIND_MOD  = 5'd4;
  localparam logic [KindW-1:0] KIND_AND  = 5'd5;
  localparam logic [KindW-1:0] KIND_OR   = 5'd6;
  localparam logic [KindW-1:0] KIND_XOR  = 5'd7;
  localparam logic [KindW-1:0] KIND_SHL  = 5'd8;
  localparam logic [KindW-1:0] KIND_SHR  = 5'd9;
  localparam logic [KindW-1:0] KIND_EQ   = 5'd10;
  localparam logic [KindW-1:0] KIND_NE   = 5'd11;
  localparam logic [KindW-1:0] KIND_LT   = 5'd12;
  localparam logic [KindW-1:0] KIND_LE   = 5'd13;
  localparam logic [KindW-1:0] KIND_GT   = 5'd14;
  localparam logic [KindW-1:0] KIND_GE   = 5'd15;
  localparam logic [KindW-1:0] KIND_LAND = 5'd16;
  localparam logic [KindW-1:0] KIND_LOR  = 5'd17;

  // One stage of the division pipeline; every item passes through it.
  typedef struct packed {
    logic             valid;
    logic             is_div;
    logic             is_mod;
    logic             neg_q;
    logic             neg_r;
    logic             dz;
    logic [DataW-1:0] res;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] den;
  } i64a_stage_t;

endpackage

// ===== design/i64a_in_if.sv =====
interface i64a_in_if;
  import i64alu_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [DataW-1:0] operand_a;
  logic [DataW-1:0] operand_b;
  logic             is_signed;
  modport source (output valid, kind, operand_a, operand_b, is_signed, input ready);
  modport sink (input valid, kind, operand_a, operand_b, is_signed, output ready);
endinterface

// ===== design/i64a_out_if.sv =====
interface i64a_out_if;
  import i64alu_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] result;
  logic             div_zero;
  modport source (output valid, result, div_zero, input ready);
  modport sink (input valid, result, div_zero, output ready);
endinterface

// ===== design/int64_alu_with_division_core.sv =====
// Channel  Direction  Payload
// in_ch    sink       kind, operand_a, operand_b, is_signed
// out_ch   source     result, div_zero
//
// Every item passes through the input register, operate, multiply sum,
// 64 division steps of one quotient bit each, and the output register.
// One item is accepted every cycle unless out_ch stalls; the 64-step divider sets the depth.
// Reset (synchronous, rst_n low) clears the valid bits only.
// While a result waits on out_ch the whole pipeline holds and in_ch is not ready.
module int64_alu_with_division_core
  import i64alu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  i64a_in_if.sink      in_ch,
  i64a_out_if.source   out_ch
);

  logic en;

  logic             s0_valid_r;
  logic [KindW-1:0] s0_kind_r;
  logic [DataW-1:0] s0_a_r;
  logic [DataW-1:0] s0_b_r;
  logic             s0_sgn_r;

  logic [DataW-1:0] s1_res_nxt;
  logic [DataW-1:0] s1_na_nxt;
  logic [DataW-1:0] s1_nb_nxt;
  logic [ShiftW-1:0] sh;

  logic             s1_valid_r;
  logic             s1_ismul_r;
  logic             s1_isdiv_r;
  logic             s1_ismod_r;
  logic             s1_negq_r;
  logic             s1_negr_r;
  logic             s1_dz_r;
  logic [DataW-1:0] s1_res_r;
  logic [DataW-1:0] s1_na_r;
  logic [DataW-1:0] s1_nb_r;
  logic [DataW-1:0] s1_pll_r;
  logic [HalfW-1:0] s1_plh_r;
  logic [HalfW-1:0] s1_phl_r;

  i64a_stage_t      s2_nxt;
  i64a_stage_t      pipe [DataW+1];

  logic [DataW-1:0] fin_nxt;
  logic             out_valid_r;
  logic [DataW-1:0] out_result_r;
  logic             out_dz_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_kind_r <= in_ch.kind;
      s0_a_r    <= in_ch.operand_a;
      s0_b_r    <= in_ch.operand_b;
      s0_sgn_r  <= in_ch.is_signed;
    end
  end

  // Everything but multiply, divide and modulo finishes here.
  always_comb begin
    sh = s0_b_r[ShiftW-1:0];
    case (s0_kind_r)
      KIND_ADD:  s1_res_nxt = s0_a_r + s0_b_r;
      KIND_SUB:  s1_res_nxt = s0_a_r - s0_b_r;
      KIND_AND:  s1_res_nxt = s0_a_r & s0_b_r;
      KIND_OR:   s1_res_nxt = s0_a_r | s0_b_r;
      KIND_XOR:  s1_res_nxt = s0_a_r ^ s0_b_r;
      KIND_SHL:  s1_res_nxt = s0_a_r << sh;
      KIND_SHR:  s1_res_nxt = s0_sgn_r ? DataW'($signed(s0_a_r) >>> sh) : s0_a_r >> sh;
      KIND_EQ:   s1_res_nxt = DataW'(s0_a_r == s0_b_r);
      KIND_NE:   s1_res_nxt = DataW'(s0_a_r != s0_b_r);
      KIND_LT:   s1_res_nxt = DataW'($signed(s0_a_r) < $signed(s0_b_r));
      KIND_LE:   s1_res_nxt = DataW'($signed(s0_a_r) <= $signed(s0_b_r));
      KIND_GT:   s1_res_nxt = DataW'($signed(s0_a_r) > $signed(s0_b_r));
      KIND_GE:   s1_res_nxt = DataW'($signed(s0_a_r) >= $signed(s0_b_r));
      KIND_LAND: s1_res_nxt = DataW'((s0_a_r != '0) && (s0_b_r != '0));
      KIND_LOR:  s1_res_nxt = DataW'((s0_a_r != '0) || (s0_b_r != '0));
      default:   s1_res_nxt = '0;
    endcase
    s1_na_nxt = (s0_sgn_r && s0_a_r[DataW-1]) ? '0 - s0_a_r : s0_a_r;
    s1_nb_nxt = (s0_sgn_r && s0_b_r[DataW-1]) ? '0 - s0_b_r : s0_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ismul_r <= (s0_kind_r == KIND_MUL);
      s1_isdiv_r <= (s0_kind_r == KIND_DIV);
      s1_ismod_r <= (s0_kind_r == KIND_MOD);
      s1_negq_r  <= s0_sgn_r && (s0_a_r[DataW-1] ^ s0_b_r[DataW-1]);
      s1_negr_r  <= s0_sgn_r && s0_a_r[DataW-1];
      s1_dz_r    <= (s0_b_r == '0);
      s1_res_r   <= s1_res_nxt;
      s1_na_r    <= s1_na_nxt;
      s1_nb_r    <= s1_nb_nxt;
      // Only the low half of each cross product reaches the wrapped result.
      s1_pll_r   <= s0_a_r[HalfW-1:0] * s0_b_r[HalfW-1:0];
      s1_plh_r   <= HalfW'(s0_a_r[HalfW-1:0] * s0_b_r[DataW-1:HalfW]);
      s1_phl_r   <= HalfW'(s0_a_r[DataW-1:HalfW] * s0_b_r[HalfW-1:0]);
    end
  end

  always_comb begin
    s2_nxt.valid  = s1_valid_r;
    s2_nxt.is_div = s1_isdiv_r;
    s2_nxt.is_mod = s1_ismod_r;
    s2_nxt.neg_q  = s1_negq_r;
    s2_nxt.neg_r  = s1_negr_r;
    s2_nxt.dz     = s1_dz_r && (s1_isdiv_r || s1_ismod_r);
    s2_nxt.res    = s1_ismul_r ? s1_pll_r + {s1_plh_r + s1_phl_r, {HalfW{1'b0}}} : s1_res_r;
    s2_nxt.rem    = '0;
    s2_nxt.quo    = s1_na_r;
    s2_nxt.den    = s1_nb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe[0].valid <= 1'b0;
    end else if (en) begin
      pipe[0].valid <= s2_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].is_div <= s2_nxt.is_div;
      pipe[0].is_mod <= s2_nxt.is_mod;
      pipe[0].neg_q  <= s2_nxt.neg_q;
      pipe[0].neg_r  <= s2_nxt.neg_r;
      pipe[0].dz     <= s2_nxt.dz;
      pipe[0].res    <= s2_nxt.res;
      pipe[0].rem    <= s2_nxt.rem;
      pipe[0].quo    <= s2_nxt.quo;
      pipe[0].den    <= s2_nxt.den;
    end
  end

  for (genvar i = 0; i < DataW; i++) begin : g_div
    i64a_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .stage_in  (pipe[i]),
      .stage_out (pipe[i+1])
    );
  end

  // Sign correction of quotient and remainder; a zero divisor forces zero; other kinds pass res through.
  always_comb begin
    if (pipe[DataW].dz) begin
      fin_nxt = '0;
    end else if (pipe[DataW].is_div) begin
      fin_nxt = pipe[DataW].neg_q ? '0 - pipe[DataW].quo : pipe[DataW].quo;
    end else if (pipe[DataW].is_mod) begin
      fin_nxt = pipe[DataW].neg_r ? '0 - pipe[DataW].rem : pipe[DataW].rem;
    end else begin
      fin_nxt = pipe[DataW].res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pipe[DataW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= fin_nxt;
      out_dz_r     <= pipe[DataW].dz;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.result   = out_result_r;
  assign out_ch.div_zero = out_dz_r;

endmodule

// ===== design/i64a_div_step.sv =====
module i64a_div_step
  import i64alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  i64a_stage_t stage_in,
  output i64a_stage_t stage_out
);

  logic [DataW:0]   rem_sh;
  logic [DataW+1:0] trial;
  logic             ge;
  i64a_stage_t      stage_r;
  i64a_stage_t      stage_nxt;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    rem_sh    = {stage_in.rem, stage_in.quo[DataW-1]};
    trial     = {1'b0, rem_sh} - {2'b00, stage_in.den};
    ge        = !trial[DataW+1];
    stage_nxt = stage_in;
    stage_nxt.rem = ge ? trial[DataW-1:0] : rem_sh[DataW-1:0];
    stage_nxt.quo = {stage_in.quo[DataW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.is_div <= stage_nxt.is_div;
      stage_r.is_mod <= stage_nxt.is_mod;
      stage_r.neg_q  <= stage_nxt.neg_q;
      stage_r.neg_r  <= stage_nxt.neg_r;
      stage_r.dz     <= stage_nxt.dz;
      stage_r.res    <= stage_nxt.res;
      stage_r.rem    <= stage_nxt.rem;
      stage_r.quo    <= stage_nxt.quo;
      stage_r.den    <= stage_nxt.den;
    end
  end

  assign stage_out = stage_r;

endmodule

// ===== design/i64a_checker.sv =====
`include "int64_alu_with_division_core_macros.svh"

module i64a_checker
  import i64alu_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DataW-1:0] out_result,
  input logic             out_div_zero
);

  `I64A_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid, "output valid after reset")
  `I64A_ASSERT_IMP(a_ready_follows_out, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")
  `I64A_ASSERT_IMP(a_dz_zero, clk, rst_n, out_valid && out_div_zero, out_result == '0, "zero divisor result not zero")
  `I64A_ASSERT_NEXT(a_out_hold, clk, rst_n && out_valid && !out_ready, out_valid && $stable(out_result) && $stable(out_div_zero), "stalled result changed")

endmodule

bind int64_alu_with_division_core i64a_checker u_i64a_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_result   (out_ch.result),
  .out_div_zero (out_ch.div_zero)
);
